// ===== sv/cwc_pkg.sv =====
// cwc_pkg: types, character codes and defaults for the comment and whitespace compressor
// used by every module of the block; depends on nothing
package cwc_pkg;

  localparam logic [31:0] MAX_TEXT_BYTES_DEF = 32'd65535;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_SLASH,
    MODE_LINE,
    MODE_BLOCK,
    MODE_QUOTE
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_char;
    logic        out_end;
    logic [15:0] out_length;
  } out_item_t;

  // everything one input byte produces, handed from scanner to emitter
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      n_chars;
    logic            term;
    logic [15:0]     length;
  } step_t;

endpackage

// ===== sv/cwc_scan.sv =====
// cwc_scan: scanner state and the per-byte step logic of the compressor
// depends on cwc_pkg
module cwc_scan #(
  parameter logic [31:0] MAX_TEXT_BYTES = cwc_pkg::MAX_TEXT_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cwc_pkg::in_item_t item,
  input  logic             advance,
  output cwc_pkg::step_t   step
);

  localparam logic [15:0] CountCap =
    (MAX_TEXT_BYTES > 32'd65535) ? 16'hFFFF : MAX_TEXT_BYTES[15:0];

  cwc_pkg::scan_mode_t mode, mode_step, mode_next;
  logic        star_seen, star_next;
  logic        newline_pending, nl_step, newline_pending_next;
  logic        space_pending, sp_step, space_pending_next;
  logic [15:0] emitted_count, emitted_count_next;

  logic [7:0]      c;
  logic            c_nl, c_sp, c_plain;
  logic [3:0][7:0] chars;
  logic [1:0]      cnt;
  logic [16:0]     sum;
  logic [15:0]     length;

  assign c       = item.in_byte;
  assign c_nl    = (c == cwc_pkg::CH_LF) || (c == cwc_pkg::CH_CR);
  assign c_sp    = (c == cwc_pkg::CH_SPACE) || (c == cwc_pkg::CH_TAB);
  assign c_plain = !c_nl && !c_sp && (c != cwc_pkg::CH_SLASH);

  // next state
  always_comb begin
    mode_step = mode;
    star_next = star_seen;
    nl_step   = newline_pending;
    sp_step   = space_pending;
    unique case (mode)
      cwc_pkg::MODE_SLASH: begin
        if (c == cwc_pkg::CH_SLASH) begin
          mode_step = cwc_pkg::MODE_LINE;
        end else if (c == cwc_pkg::CH_STAR) begin
          mode_step = cwc_pkg::MODE_BLOCK;
          star_next = 1'b1;
        end else begin
          mode_step = cwc_pkg::MODE_NORMAL;
          nl_step   = c_nl;
          sp_step   = c_sp;
          if (c == cwc_pkg::CH_QUOTE) mode_step = cwc_pkg::MODE_QUOTE;
        end
      end
      cwc_pkg::MODE_LINE: begin
        if (c == cwc_pkg::CH_LF) begin
          nl_step   = 1'b1;
          mode_step = cwc_pkg::MODE_NORMAL;
        end
      end
      cwc_pkg::MODE_BLOCK: begin
        if (star_seen && c == cwc_pkg::CH_SLASH) begin
          mode_step = cwc_pkg::MODE_NORMAL;
          star_next = 1'b0;
        end else begin
          star_next = (c == cwc_pkg::CH_STAR);
        end
      end
      cwc_pkg::MODE_QUOTE: begin
        if (c == cwc_pkg::CH_QUOTE) mode_step = cwc_pkg::MODE_NORMAL;
      end
      default: begin
        mode_step = cwc_pkg::MODE_NORMAL;
        if (c == cwc_pkg::CH_SLASH) begin
          mode_step = cwc_pkg::MODE_SLASH;
        end else if (c_nl) begin
          nl_step = 1'b1;
        end else if (c_sp) begin
          sp_step = 1'b1;
        end else begin
          nl_step = 1'b0;
          sp_step = 1'b0;
          if (c == cwc_pkg::CH_QUOTE) mode_step = cwc_pkg::MODE_QUOTE;
        end
      end
    endcase
    if (item.in_last) begin
      mode_next            = cwc_pkg::MODE_NORMAL;
      star_next            = 1'b0;
      newline_pending_next = 1'b0;
      space_pending_next   = 1'b0;
      emitted_count_next   = 16'd0;
    end else begin
      mode_next            = mode_step;
      newline_pending_next = nl_step;
      space_pending_next   = sp_step;
      emitted_count_next   = length;
    end
  end

  // emitted characters
  always_comb begin
    chars = '0;
    cnt   = 2'd0;
    unique case (mode) inside
      cwc_pkg::MODE_SLASH: begin
        if (c != cwc_pkg::CH_SLASH && c != cwc_pkg::CH_STAR) begin
          if (newline_pending || space_pending) begin
            chars[cnt] = newline_pending ? cwc_pkg::CH_LF : cwc_pkg::CH_SPACE;
            cnt        = cnt + 2'd1;
          end
          chars[cnt] = cwc_pkg::CH_SLASH;
          cnt        = cnt + 2'd1;
          if (c_plain) begin
            chars[cnt] = c;
            cnt        = cnt + 2'd1;
          end
        end
      end
      cwc_pkg::MODE_LINE, cwc_pkg::MODE_BLOCK: begin
        cnt = 2'd0;
      end
      cwc_pkg::MODE_QUOTE: begin
        chars[0] = c;
        cnt      = 2'd1;
      end
      default: begin
        if (c_plain) begin
          if (newline_pending || space_pending) begin
            chars[cnt] = newline_pending ? cwc_pkg::CH_LF : cwc_pkg::CH_SPACE;
            cnt        = cnt + 2'd1;
          end
          chars[cnt] = c;
          cnt        = cnt + 2'd1;
        end
      end
    endcase
    // held slash flushed at end of text
    if (item.in_last && mode_step == cwc_pkg::MODE_SLASH) begin
      if (nl_step || sp_step) begin
        chars[cnt] = nl_step ? cwc_pkg::CH_LF : cwc_pkg::CH_SPACE;
        cnt        = cnt + 2'd1;
      end
      chars[cnt] = cwc_pkg::CH_SLASH;
      cnt        = cnt + 2'd1;
    end
    sum    = {1'b0, emitted_count} + {15'd0, cnt};
    length = (sum > {1'b0, CountCap}) ? CountCap : sum[15:0];
  end

  assign step.chars   = chars;
  assign step.n_chars = cnt;
  assign step.term    = item.in_last;
  assign step.length  = length;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= cwc_pkg::MODE_NORMAL;
      star_seen       <= 1'b0;
      newline_pending <= 1'b0;
      space_pending   <= 1'b0;
      emitted_count   <= 16'd0;
    end else if (advance) begin
      mode            <= mode_next;
      star_seen       <= star_next;
      newline_pending <= newline_pending_next;
      space_pending   <= space_pending_next;
      emitted_count   <= emitted_count_next;
    end
  end

endmodule

// ===== sv/cwc_emit.sv =====
// cwc_emit: walks the results of one byte out through the result register
// depends on cwc_pkg
module cwc_emit (
  input  logic               clk,
  input  logic               rst,
  input  cwc_pkg::step_t     step,
  input  logic               full,
  input  logic               res_stall,
  output logic               retire,
  output logic               res_valid,
  output cwc_pkg::out_item_t res_item
);

  logic [1:0]         idx;
  logic [2:0]         n_total;
  logic               out_free, load, idx_last;
  cwc_pkg::out_item_t item_sel;

  assign n_total  = {1'b0, step.n_chars} + {2'b00, step.term};
  assign out_free = !res_valid || !res_stall;
  assign load     = full && (n_total != 3'd0) && out_free;
  assign idx_last = ({1'b0, idx} == n_total - 3'd1);
  assign retire   = full && ((n_total == 3'd0) || (out_free && idx_last));

  always_comb begin
    if (idx < step.n_chars) begin
      item_sel.out_char   = step.chars[idx];
      item_sel.out_end    = 1'b0;
      item_sel.out_length = 16'd0;
    end else begin
      item_sel.out_char   = 8'd0;
      item_sel.out_end    = 1'b1;
      item_sel.out_length = step.length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (out_free) res_valid <= load;
      if (load) idx <= idx_last ? 2'd0 : idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_item <= item_sel;
  end

endmodule

// ===== sv/comment_whitespace_compressor.sv =====
// comment_whitespace_compressor: top level, input register, scanner and emitter
// depends on cwc_pkg, cwc_scan, cwc_emit
//
//   channel   valid       stall       payload                   direction
//   text      byte_valid  byte_stall  byte_item (in_item_t)     into block
//   result    res_valid   res_stall   res_item  (out_item_t)    out of block
//
// one byte per cycle while each byte yields at most one result and res_stall is low;
// bytes with more results hold the input register, paced by the single result register
// a byte passes the input register, then the result register, before its first result
// reset clears scanner state; no clearing pass
// a stalled result register backs up into byte_stall in the same cycle
module comment_whitespace_compressor #(
  parameter logic [31:0] MAX_TEXT_BYTES = cwc_pkg::MAX_TEXT_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  cwc_pkg::in_item_t  byte_item,
  output logic               res_valid,
  input  logic               res_stall,
  output cwc_pkg::out_item_t res_item
);

  logic              in_full;
  cwc_pkg::in_item_t in_q;
  logic              retire, accept;
  cwc_pkg::step_t    step;

  assign byte_stall = in_full && !retire;
  assign accept     = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (retire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) in_q <= byte_item;
  end

  cwc_scan #(
    .MAX_TEXT_BYTES(MAX_TEXT_BYTES)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .item   (in_q),
    .advance(retire),
    .step   (step)
  );

  cwc_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .full     (in_full),
    .res_stall(res_stall),
    .retire   (retire),
    .res_valid(res_valid),
    .res_item (res_item)
  );

endmodule

// ===== sv/cwc_check.sv =====
// cwc_check: port-level checks on the compressor's result channel
// depends on cwc_pkg; bound to comment_whitespace_compressor
module cwc_check (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_stall,
  input cwc_pkg::out_item_t res_item
);

  // stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_item))
    else $error("stalled result changed");

  // terminator carries no character
  a_end_char: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.out_end |-> res_item.out_char == 8'd0)
    else $error("terminator with character");

  // length only in the terminator
  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_item.out_end |-> res_item.out_length == 16'd0)
    else $error("length outside terminator");

  // no result right after reset
  a_rst_idle: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind comment_whitespace_compressor cwc_check u_check (
  .clk      (clk),
  .rst      (rst),
  .res_valid(res_valid),
  .res_stall(res_stall),
  .res_item (res_item)
);
